FILE: rtl/pgc_pkg.sv
// shared types, constants and the root/divide step for the gamma 2.0 converter
package pgc_pkg;

    // channel and pipeline geometry
    localparam int CH_W       = 15;
    localparam int PROD_W     = 2 * CH_W;
    localparam int NSTEP      = CH_W;
    localparam int PIPE_DEPTH = NSTEP + 1;
    localparam int REM_W      = CH_W + 1;

    // apb register map
    localparam int APB_AW              = 3;
    localparam logic REG_IDX_DIRECTION = 1'b0;

    // direction codes
    localparam logic MODE_SQUARE = 1'b0;
    localparam logic MODE_ROOT   = 1'b1;

    // fixed point constants
    localparam logic [CH_W-1:0] ONE_Q12 = CH_W'(4096);
    localparam logic [CH_W-1:0] CH_MAX  = '1;

    typedef struct packed {
        logic signed [15:0] red_in;
        logic signed [15:0] green_in;
        logic signed [15:0] blue_in;
        logic signed [15:0] alpha_in;
    } pgc_in_t;

    typedef struct packed {
        logic        [CH_W-1:0] red_out;
        logic        [CH_W-1:0] green_out;
        logic        [CH_W-1:0] blue_out;
        logic signed [15:0]     alpha_out;
    } pgc_out_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [CH_W-1:0]  q;
    } pgc_step_t;

    // one result bit: restoring divide (one dividend bit) or square root (two bits)
    function automatic pgc_step_t pgc_step(input logic mode, input logic [REM_W-1:0] rem,
                                           input logic [1:0] bits, input logic [CH_W-1:0] q,
                                           input logic [CH_W-1:0] d);
        logic [REM_W+1:0] cand;
        logic [REM_W+1:0] sub;
        pgc_step_t        res;
        if (mode == MODE_ROOT) begin
            cand = {rem, bits};
            sub  = {1'b0, q, 2'b01};
        end else begin
            cand = {1'b0, rem, bits[0]};
            sub  = {3'b000, d};
        end
        if (cand >= sub) begin
            res.rem = REM_W'(cand - sub);
            res.q   = {q[CH_W-2:0], 1'b1};
        end else begin
            res.rem = cand[REM_W-1:0];
            res.q   = {q[CH_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

FILE: rtl/pgc_chan.sv
// one colour channel: multiplier stage, then one divide/root bit per stage
module pgc_chan
    import pgc_pkg::*;
(
    input  logic              aclk,
    input  logic              enable,
    input  logic              mode,
    input  logic signed [15:0] chan,
    input  logic signed [15:0] alpha,
    output logic [CH_W-1:0]   result
);

    // stage registers, index is the number of result bits done
    logic [PROD_W-1:0] n_reg    [0:NSTEP-1];
    logic [CH_W-1:0]   d_reg    [0:NSTEP-1];
    logic              mode_reg [0:NSTEP-1];
    logic              zero_reg [0:NSTEP];
    logic              sat_reg  [1:NSTEP];
    logic [REM_W-1:0]  rem_reg  [1:NSTEP-1];
    logic [CH_W-1:0]   q_reg    [1:NSTEP];

    logic [CH_W-1:0]   c_mag;
    logic [CH_W-1:0]   ua;
    logic [CH_W-1:0]   op_b;
    logic [PROD_W-1:0] prod;
    logic              zero_next;

    // operand select: c*c over a for square, c*a under the root
    assign c_mag     = chan[CH_W-1:0];
    assign ua        = (!alpha[15] && (alpha != '0)) ? alpha[CH_W-1:0] : ONE_Q12;
    assign op_b      = (mode == MODE_ROOT) ? ua : c_mag;
    assign prod      = PROD_W'(c_mag) * PROD_W'(op_b);
    assign zero_next = chan[15] || (chan == '0);

    // multiplier stage
    always_ff @(posedge aclk) begin
        if (enable) begin
            n_reg[0]    <= prod;
            d_reg[0]    <= ua;
            mode_reg[0] <= mode;
            zero_reg[0] <= zero_next;
        end
    end

    // bit stages
    for (genvar j = 1; j <= NSTEP; j++) begin : g_step
        localparam int K = NSTEP - j;
        logic [REM_W-1:0] rem_in;
        logic [CH_W-1:0]  q_in;
        logic             sat_in;
        logic [1:0]       bits;
        pgc_step_t        st;

        if (j == 1) begin : g_first
            // square mode starts with the upper half of the dividend; overflow check here
            assign rem_in = (mode_reg[0] == MODE_ROOT) ? '0
                                                       : REM_W'(n_reg[0][PROD_W-1:CH_W]);
            assign q_in   = '0;
            assign sat_in = (mode_reg[0] == MODE_SQUARE) && (n_reg[0][PROD_W-1:CH_W] >= d_reg[0]);
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign sat_in = sat_reg[j-1];
        end

        assign bits = (mode_reg[j-1] == MODE_ROOT) ? n_reg[j-1][2*K+1:2*K]
                                                   : {1'b0, n_reg[j-1][K]};
        assign st   = pgc_step(mode_reg[j-1], rem_in, bits, q_in, d_reg[j-1]);

        always_ff @(posedge aclk) begin
            if (enable) begin
                zero_reg[j] <= zero_reg[j-1];
                sat_reg[j]  <= sat_in;
                q_reg[j]    <= st.q;
            end
        end

        if (j < NSTEP) begin : g_carry
            always_ff @(posedge aclk) begin
                if (enable) begin
                    n_reg[j]    <= n_reg[j-1];
                    d_reg[j]    <= d_reg[j-1];
                    mode_reg[j] <= mode_reg[j-1];
                    rem_reg[j]  <= st.rem;
                end
            end
        end
    end

    // non-positive channel gives zero, square overflow clamps
    assign result = zero_reg[NSTEP] ? '0 : (sat_reg[NSTEP] ? CH_MAX : q_reg[NSTEP]);

endmodule

FILE: rtl/premultiplied_gamma_two_converter_core.sv
// top level of the premultiplied gamma 2.0 converter: handshake, register, pipeline control
//
//   port group   direction  handshake       payload
//   s_*          in         s_valid/s_ready s_data (pgc_in_t), one rgba word
//   m_*          out        m_valid/m_ready m_data (pgc_out_t), one converted word
//   apb          in/out     psel/penable    paddr, pwdata, prdata (direction at 0x0)
//
// 16 register stages: one multiplier stage and 15 divide/root stages, one result bit each.
// a word is accepted every cycle unless stalled; m_valid rises as it enters the last stage.
// the whole pipeline holds while m_valid is high and m_ready is low; nothing is dropped.
// aresetn (synchronous) clears the stage valid bits and direction; no clearing pass.
module premultiplied_gamma_two_converter_core
    import pgc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pgc_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pgc_out_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LAST = PIPE_DEPTH - 1;

    logic                  direction_reg;
    logic                  direction_next;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic signed [15:0]    alpha_reg [0:LAST];
    logic                  enable;
    logic                  cfg_write;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[APB_AW-1] == REG_IDX_DIRECTION);
    assign direction_next = cfg_write ? pwdata[0] : direction_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= MODE_SQUARE;
        end else begin
            direction_reg <= direction_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1] == REG_IDX_DIRECTION) begin
            prdata[0] = direction_reg;
        end
    end

    // pipeline advance: everything moves unless the output word is stuck
    assign enable     = !valid_reg[LAST] || m_ready;
    assign s_ready    = enable;
    assign valid_next = enable ? {valid_reg[LAST-1:0], s_valid} : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // alpha travels alongside the channel stages
    always_ff @(posedge aclk) begin
        if (enable) begin
            alpha_reg[0] <= s_data.alpha_in;
            for (int i = 1; i <= LAST; i++) begin
                alpha_reg[i] <= alpha_reg[i-1];
            end
        end
    end

    // colour channel pipelines
    pgc_chan u_red (
        .aclk   (aclk),
        .enable (enable),
        .mode   (direction_reg),
        .chan   (s_data.red_in),
        .alpha  (s_data.alpha_in),
        .result (m_data.red_out)
    );

    pgc_chan u_green (
        .aclk   (aclk),
        .enable (enable),
        .mode   (direction_reg),
        .chan   (s_data.green_in),
        .alpha  (s_data.alpha_in),
        .result (m_data.green_out)
    );

    pgc_chan u_blue (
        .aclk   (aclk),
        .enable (enable),
        .mode   (direction_reg),
        .chan   (s_data.blue_in),
        .alpha  (s_data.alpha_in),
        .result (m_data.blue_out)
    );

    assign m_data.alpha_out = alpha_reg[LAST];
    assign m_valid          = valid_reg[LAST];

    // a stall freezes every stage valid bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        !enable |=> $stable(valid_reg))
        else $error("stage valid bits moved during a stall");

    // an accepted word enters stage 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        enable |=> valid_reg[0] == $past(s_valid))
        else $error("stage 0 valid does not follow the accepted word");

    // a word in the next-to-last stage reaches the output when the pipe moves
    assert property (@(posedge aclk) disable iff (!aresetn)
        (enable && valid_reg[LAST-1]) |=> m_valid)
        else $error("word lost before the output stage");

    // reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> valid_reg == '0)
        else $error("pipeline not empty after reset");

endmodule

FILE: test/tb_premultiplied_gamma_two_converter_core.sv
// self-checking testbench for the premultiplied gamma 2.0 converter core
module tb_premultiplied_gamma_two_converter_core;
    import pgc_pkg::*;

    localparam logic [APB_AW-1:0] DIRECTION_ADDR = APB_AW'(4 * REG_IDX_DIRECTION);
    localparam logic [APB_AW-1:0] UNMAPPED_ADDR  = APB_AW'(4);
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_PIXELS = 330;
    localparam int LONG_HOLD    = 200;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    pgc_in_t           s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    pgc_out_t          m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    pgc_in_t  pending_pixels[$];
    pgc_out_t predicted_pixels[$];
    int       pixels_sent   = 0;
    int       pixels_taken  = 0;
    int       error_count   = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       hold_left     = 0;
    logic     hold_request  = 1'b0;
    logic     hold_done     = 1'b0;
    logic     direction_cfg = MODE_SQUARE;

    // corner pixels, {red, green, blue, alpha}
    pgc_in_t corner_pixels[12] = '{
        {16'h0000, 16'h0000, 16'h0000, 16'h0000},
        {16'h8000, 16'h8000, 16'h8000, 16'h8000},
        {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
        {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
        {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000},
        {16'h0001, 16'h0001, 16'h0001, 16'h7FFF},
        {16'h1000, 16'h1000, 16'h1000, 16'h1000},
        {16'hFFFF, 16'h0001, 16'h0000, 16'h1000},
        {16'h0800, 16'h2000, 16'h4000, 16'hFFFF},
        {16'h0064, 16'h00C8, 16'h012C, 16'h7FFF},
        {16'h5555, 16'h2AAA, 16'h5555, 16'h2AAA},
        {16'h7FFF, 16'h0001, 16'h4000, 16'h8000}
    };

    premultiplied_gamma_two_converter_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // floor of the square root, bit by bit from the top
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // one colour channel: c*c/a or sqrt(c*a), a falls back to one when not positive
    function automatic logic [CH_W-1:0] convert_channel(input logic signed [15:0] chan,
                                                        input logic signed [15:0] alpha,
                                                        input logic mode);
        longint unsigned c;
        longint unsigned a;
        longint unsigned r;
        if (chan <= 0)
            return '0;
        c = longint'(chan);
        a = (alpha > 0) ? longint'(alpha) : longint'(ONE_Q12);
        if (mode == MODE_SQUARE)
            r = (c * c) / a;
        else
            r = floor_root(c * a);
        if (r > CH_MAX)
            r = CH_MAX;
        return CH_W'(r);
    endfunction

    function automatic pgc_out_t convert_pixel(input pgc_in_t px, input logic mode);
        pgc_out_t res;
        res.red_out   = convert_channel(px.red_in, px.alpha_in, mode);
        res.green_out = convert_channel(px.green_in, px.alpha_in, mode);
        res.blue_out  = convert_channel(px.blue_in, px.alpha_in, mode);
        res.alpha_out = px.alpha_in;
        return res;
    endfunction

    // mostly well-formed premultiplied pixels, some raw noise and tiny alphas
    function automatic pgc_in_t random_pixel();
        pgc_in_t     px;
        int unsigned kind;
        kind = $urandom_range(9);
        if (kind < 6) begin
            px.alpha_in = 16'($urandom_range(32767, 1));
            px.red_in   = 16'($urandom_range(int'(px.alpha_in)));
            px.green_in = 16'($urandom_range(int'(px.alpha_in)));
            px.blue_in  = 16'($urandom_range(int'(px.alpha_in)));
        end else if (kind < 8) begin
            px = {$urandom, $urandom};
        end else begin
            px          = {$urandom, $urandom};
            px.alpha_in = 16'(int'($urandom_range(64)) - 32);
        end
        return px;
    endfunction

    // apb write: setup cycle, then access until pready
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for every queued word to be taken and every result checked
    task automatic drain_pipeline();
        while (pending_pixels.size() != 0 || pixels_taken != pixels_sent ||
               predicted_pixels.size() != 0)
            @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    // sender: offers the next queued word, holds it until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (pixels_taken == pixels_sent) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data      <= pending_pixels.pop_front();
                s_valid     <= 1'b1;
                pixels_sent <= pixels_sent + 1;
            end else begin
                s_valid <= 1'b0;
                s_data  <= {$urandom, $urandom};
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: tracks the register, predicts accepted words, checks results
    always @(posedge aclk) begin
        pgc_out_t want;
        if (!aresetn) begin
            direction_cfg = MODE_SQUARE;
        end else begin
            if (psel && penable && pwrite && pready && paddr == DIRECTION_ADDR)
                direction_cfg = pwdata[0];
            if (s_valid && s_ready) begin
                predicted_pixels.push_back(convert_pixel(s_data, direction_cfg));
                pixels_taken <= pixels_taken + 1;
            end
            if (m_valid && m_ready) begin
                if (predicted_pixels.size() == 0) begin
                    $error("unexpected result word %h", m_data);
                    error_count++;
                end else begin
                    want = predicted_pixels.pop_front();
                    if (m_data.red_out !== want.red_out) begin
                        $error("red_out: expected %0d, got %0d", want.red_out, m_data.red_out);
                        error_count++;
                    end
                    if (m_data.green_out !== want.green_out) begin
                        $error("green_out: expected %0d, got %0d", want.green_out,
                               m_data.green_out);
                        error_count++;
                    end
                    if (m_data.blue_out !== want.blue_out) begin
                        $error("blue_out: expected %0d, got %0d", want.blue_out,
                               m_data.blue_out);
                        error_count++;
                    end
                    if (m_data.alpha_out !== want.alpha_out) begin
                        $error("alpha_out: expected %0d, got %0d", want.alpha_out,
                               m_data.alpha_out);
                        error_count++;
                    end
                end
            end
        end
    end

    // stimulus sequence
    initial begin
        logic phase_mode;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // corner pixels in square mode, upper write bits must be dropped
        write_reg(DIRECTION_ADDR, 32'hFFFF_FFFE);
        foreach (corner_pixels[i])
            pending_pixels.push_back(corner_pixels[i]);
        drain_pipeline();

        // corner pixels in root mode, a write off the map must not disturb it
        write_reg(DIRECTION_ADDR, 32'h0000_0001);
        write_reg(UNMAPPED_ADDR, 32'h0000_0000);
        foreach (corner_pixels[i])
            pending_pixels.push_back(corner_pixels[i]);
        drain_pipeline();

        // random phases: sender-light, receiver-light, then no idling with one long hold
        for (int p = 0; p < PHASE_COUNT; p++) begin
            phase_mode = (((p + 1) / 2) % 2 == 1) ? MODE_ROOT : MODE_SQUARE;
            write_reg(DIRECTION_ADDR, {31'($urandom), phase_mode});
            if (p < 2) begin
                send_idle_pct = 13;
                recv_idle_pct = 62;
            end else if (p < 4) begin
                send_idle_pct = 62;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 4)
                hold_request = 1'b1;
            repeat (PHASE_PIXELS)
                pending_pixels.push_back(random_pixel());
            drain_pipeline();
        end

        if (error_count == 0)
            $display("premultiplied_gamma_two_converter_core regression: pass");
        else
            $display("premultiplied_gamma_two_converter_core regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("premultiplied_gamma_two_converter_core regression: fail");
        $finish;
    end

endmodule

FILE: premultiplied_gamma_two_converter_core.f
rtl/pgc_pkg.sv
rtl/pgc_chan.sv
rtl/premultiplied_gamma_two_converter_core.sv
test/tb_premultiplied_gamma_two_converter_core.sv
